FILE: design/swap_slot_table_core_defines.svh
`ifndef SWAP_SLOT_TABLE_CORE_DEFINES_SVH
`define SWAP_SLOT_TABLE_CORE_DEFINES_SVH

// Clocked implication check, off while reset is high.
`define SST_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Same, with the consequent in the next cycle.
`define SST_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/sst_pkg.sv
package sst_pkg;

   localparam int SLOTS            = 1024;
   localparam int SECTORS_PER_SLOT = 8;
   localparam int IDX_W            = $clog2(SLOTS);
   localparam int CNT_W            = IDX_W + 1;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_FIND   = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_DUP     = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] thread_id;
      logic [19:0] page_number;
      logic        writable;
      logic [9:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [9:0]  slot_found;
      logic [12:0] first_sector;
      logic        writable_out;
   } rsp_type;

   typedef struct packed {
      logic        used;
      logic [15:0] thread;
      logic [19:0] page;
      logic        flag;
   } entry_type;

   typedef struct packed {
      logic      shift;
      entry_type tail;
   } ring_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT,
      S_FINISH
   } state_type;

   function automatic rsp_type make_rsp(logic [1:0] status, logic hit,
                                        logic [IDX_W-1:0] slot, logic flag);
      rsp_type r;
      r.status       = status;
      r.hit          = hit;
      r.slot_found   = 10'(slot);
      r.first_sector = 13'(32'(slot) * SECTORS_PER_SLOT);
      r.writable_out = flag;
      return r;
   endfunction

endpackage

FILE: design/sst_cell.sv
module sst_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  sst_pkg::entry_type  d,
   output sst_pkg::entry_type  q
);
   import sst_pkg::*;

   logic        used_ff, used_in;
   logic [15:0] thread_ff, thread_in;
   logic [19:0] page_ff, page_in;
   logic        flag_ff, flag_in;

   always_comb begin
      used_in   = shift ? d.used   : used_ff;
      thread_in = shift ? d.thread : thread_ff;
      page_in   = shift ? d.page   : page_ff;
      flag_in   = shift ? d.flag   : flag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      thread_ff <= thread_in;
      page_ff   <= page_in;
      flag_ff   <= flag_in;
   end

   assign q = '{used: used_ff, thread: thread_ff, page: page_ff, flag: flag_ff};

endmodule

FILE: design/sst_ctrl.sv
module sst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sst_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sst_pkg::rsp_type      rsp_data,
   input  logic [10:0]           slots_limit,
   input  sst_pkg::entry_type    head,
   output sst_pkg::ring_ctl_type ring
);
   import sst_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   req_type           req_ff, req_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hslot_ff, hslot_in;
   logic              hflag_ff, hflag_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  fslot_ff, fslot_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              last;
   logic [IDX_W-1:0]  k;
   logic              key_match;
   logic              rm_match;
   logic              found;
   logic              out_free;

   assign last      = (32'(step_ff) == SLOTS - 1);
   assign k         = step_ff[IDX_W-1:0];
   assign key_match = head.used && (head.thread == req_ff.thread_id)
                      && (head.page == req_ff.page_number);
   assign rm_match  = head.used && (32'(k) == 32'(req_ff.slot_index));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (req_ff.action)
         ACT_INSERT, ACT_FIND: found = key_match;
         ACT_REMOVE:           found = rm_match;
         default:              found = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_SCAN;
         S_SCAN: begin
            if (last) begin
               if (req_ff.action == ACT_INSERT && !hit_in && free_in) begin
                  state_in = S_COMMIT;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_COMMIT: if (last) state_in = S_FINISH;
         S_FINISH: if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = (state_ff == S_IDLE);
      ring.shift = (state_ff == S_SCAN) || (state_ff == S_COMMIT);
      ring.tail  = head;
      if (state_ff == S_SCAN && req_ff.action == ACT_REMOVE && rm_match) begin
         ring.tail.used = 1'b0;
      end
      if (state_ff == S_COMMIT && k == fslot_ff) begin
         ring.tail = '{used: 1'b1, thread: req_ff.thread_id,
                       page: req_ff.page_number, flag: req_ff.writable};
      end
   end

   // datapath
   always_comb begin
      step_in  = '0;
      req_in   = req_ff;
      hit_in   = hit_ff;
      hslot_in = hslot_ff;
      hflag_in = hflag_ff;
      free_in  = free_ff;
      fslot_in = fslot_ff;
      res_in   = res_ff;

      if ((state_ff == S_SCAN || state_ff == S_COMMIT) && !last) begin
         step_in = step_ff + 1'b1;
      end

      if (state_ff == S_IDLE && req_valid) begin
         req_in  = req_data;
         hit_in  = 1'b0;
         free_in = 1'b0;
      end

      if (state_ff == S_SCAN) begin
         // keep the lowest match and the lowest usable free slot
         if (found && !hit_ff) begin
            hit_in   = 1'b1;
            hslot_in = k;
            hflag_in = head.flag;
         end
         if (!head.used && !free_ff && (32'(step_ff) < 32'(slots_limit))) begin
            free_in  = 1'b1;
            fslot_in = k;
         end
         if (last) begin
            case (req_ff.action)
               ACT_INSERT: begin
                  if (hit_in) begin
                     res_in = make_rsp(ST_DUP, 1'b0, '0, 1'b0);
                  end else if (!free_in) begin
                     res_in = make_rsp(ST_FULL, 1'b0, '0, 1'b0);
                  end else begin
                     res_in = make_rsp(ST_OK, 1'b0, fslot_in, req_ff.writable);
                  end
               end
               ACT_FIND: begin
                  res_in = hit_in ? make_rsp(ST_OK, 1'b1, hslot_in, hflag_in)
                                  : make_rsp(ST_MISSING, 1'b0, '0, 1'b0);
               end
               ACT_REMOVE: begin
                  res_in = hit_in ? make_rsp(ST_OK, 1'b0, hslot_in, hflag_in)
                                  : make_rsp(ST_MISSING, 1'b0, '0, 1'b0);
               end
               default: res_in = make_rsp(ST_MISSING, 1'b0, '0, 1'b0);
            endcase
         end
      end
   end

   // result register, loads while the previous result drains
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == S_FINISH && out_free) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      hit_ff   <= hit_in;
      hslot_ff <= hslot_in;
      hflag_ff <= hflag_in;
      free_ff  <= free_in;
      fslot_ff <= fslot_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: design/swap_slot_table_core.sv
// Swap-slot table: allocates swap slots and maps (thread, page) keys to them.
// Request channel (req_*): action insert, find or remove, with key, flag and
// slot index. Response channel (rsp_*): one response per request with status,
// hit, slot, first sector and stored writable flag.
// csr_* writes the usable slot count; csr_ready is always high. Write it only
// while no request is in flight.
// Slot entries sit in a ring of cells that rotates once per scan, one slot
// per cycle past a single compare unit at the head. One request is served
// at a time: find, remove and refused inserts take one rotation from
// transfer to response; an insert that claims a slot takes a second rotation
// to write it.
// Reset frees every slot at once and sets the usable count to 1024.
// The response sits in an output register; a new request is taken and
// scanned while it waits, and a finished scan holds until rsp_ready drains it.
module swap_slot_table_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sst_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [10:0]      csr_data
);
   import sst_pkg::*;

   logic [10:0]  limit_ff, limit_in;
   entry_type    cell_q [SLOTS];
   ring_ctl_type ring;

   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid && csr_ready) ? csr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 11'd1024;
      end else begin
         limit_ff <= limit_in;
      end
   end

   sst_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .slots_limit (limit_ff),
      .head        (cell_q[0]),
      .ring        (ring)
   );

   // advance toward the head; the tail takes the head entry back
   for (genvar j = 0; j < SLOTS; j++) begin : g_cell
      if (j == SLOTS - 1) begin : g_tail
         sst_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (ring.shift),
            .d     (ring.tail),
            .q     (cell_q[j])
         );
      end else begin : g_body
         sst_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (ring.shift),
            .d     (cell_q[j+1]),
            .q     (cell_q[j])
         );
      end
   end

endmodule

FILE: design/sst_checker.sv
`include "swap_slot_table_core_defines.svh"

module sst_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sst_pkg::rsp_type rsp_data
);
   import sst_pkg::*;

   `SST_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   `SST_CHECK(a_fail_zero, rsp_valid && rsp_data.status != ST_OK, rsp_data.hit == 1'b0 && rsp_data.slot_found == 10'd0 && rsp_data.first_sector == 13'd0 && rsp_data.writable_out == 1'b0, "failed response carries data")

   `SST_CHECK(a_hit_ok, rsp_valid && rsp_data.hit, rsp_data.status == ST_OK, "hit without ok status")

   `SST_CHECK(a_sector, rsp_valid, rsp_data.first_sector == 13'(32'(rsp_data.slot_found) * SECTORS_PER_SLOT), "sector does not follow slot")

endmodule

bind swap_slot_table_core sst_checker u_sst_checker (.*);
